/* rtl/array_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue unit
// Each macro expands to one labeled concurrent assertion that is clocked on
// clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// check cons in the same cycle in which ante holds
`define APQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante holds
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/apq_pkg.sv */
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants for the array priority queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

	// defaults for the top level parameters
	localparam int DEPTH_DEF    = 8;
	localparam int PRI_BITS_DEF = 8;

	// fixed field widths
	localparam int VALUE_W  = 32;
	localparam int PRI_IN_W = 8;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 4;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} back_state_t;

	// one classified request
	typedef struct packed {
		op_t                 op;
		logic [VALUE_W-1:0]  value;
		logic [PRI_IN_W-1:0] pri;
	} cmd_t;

	// command queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

/* rtl/apq_front.sv */
// ----------------------------------------------------------------------------
// apq_front
// Request stage: registers each request, decodes its operation, masks the
// priority to the stored width and hands it to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_front #(
	parameter int PRIORITY_BITS = apq_pkg::PRI_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                operation,
	input  logic signed [apq_pkg::VALUE_W-1:0]  item_value,
	input  logic        [apq_pkg::PRI_IN_W-1:0] item_priority,
	output apq_pkg::cmd_t                       cmd,
	output logic                                cmd_valid,
	input  apq_pkg::q_status_t                  q_status
);
	import apq_pkg::*;

	localparam logic [PRI_IN_W-1:0] PRI_MASK = (PRIORITY_BITS >= PRI_IN_W) ? '1 :
		PRI_IN_W'((1 << PRIORITY_BITS) - 1);

	logic valid_s1;
	cmd_t cmd_s1;

	// hold the stage while the queue is full
	assign req_stall = valid_s1 && q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// capture and classify the request
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			cmd_s1.op    <= op_t'(operation);
			cmd_s1.value <= item_value;
			cmd_s1.pri   <= item_priority & PRI_MASK;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

/* rtl/apq_cmd_queue.sv */
// ----------------------------------------------------------------------------
// apq_cmd_queue
// Small command FIFO that decouples the request stage from the execution
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  apq_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output apq_pkg::cmd_t      head_cmd,
	output apq_pkg::q_status_t q_status
);
	import apq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             do_pop;

	assign q_status.full  = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (fill_q == '0);
	assign push           = push_valid && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head_cmd       = entries_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* rtl/apq_back.sv */
// ----------------------------------------------------------------------------
// apq_back
// Execution engine: owns the entry store, appends on enqueue, scans for the
// highest priority and closes the gap on dequeue, and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_back #(
	parameter int DEPTH         = apq_pkg::DEPTH_DEF,
	parameter int PRIORITY_BITS = apq_pkg::PRI_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  apq_pkg::cmd_t                       cmd,
	input  logic                                cmd_avail,
	output logic                                cmd_pop,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [apq_pkg::VALUE_W-1:0]  out_value,
	output logic        [apq_pkg::PRI_IN_W-1:0] out_priority,
	output logic        [apq_pkg::STATUS_W-1:0] status,
	output logic        [apq_pkg::FILL_W-1:0]   fill_level
);
	import apq_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int PRI_W = (PRIORITY_BITS < PRI_IN_W) ? PRIORITY_BITS : PRI_IN_W;
	localparam int ENT_W = VALUE_W + PRI_W;

	back_state_t state_q, state_d;

	// entry store
	logic [ENT_W-1:0] mem [DEPTH];
	logic [ENT_W-1:0] rdata_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    issue_q;
	logic             rvalid_q;
	logic [AW-1:0]    ridx_q;
	logic [AW-1:0]    last_idx;

	logic [AW-1:0]      best_idx_q;
	logic [PRI_W-1:0]   best_pri_q;
	logic [VALUE_W-1:0] best_val_q;
	logic [PRI_W-1:0]   rd_pri;
	logic [VALUE_W-1:0] rd_val;
	logic               take;
	logic [AW-1:0]      best_idx_nx;

	logic [VALUE_W-1:0]  res_val_q;
	logic [PRI_IN_W-1:0] res_pri_q;
	status_t             res_status_q;
	logic [FILL_W-1:0]   res_fill_q;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  out_val_q;
	logic [PRI_IN_W-1:0] out_pri_q;
	status_t             out_status_q;
	logic [FILL_W-1:0]   out_fill_q;

	logic full;
	logic scan_last;
	logic shift_done;
	logic out_free;

	assign full     = (count_q == CW'(DEPTH));
	assign last_idx = AW'(count_q - CW'(1));
	assign rd_pri   = rdata_q[PRI_W-1:0];
	assign rd_val   = rdata_q[ENT_W-1:PRI_W];
	assign out_free = !out_valid_q || !res_stall;

	// keep the earliest entry on equal priority
	assign take        = rvalid_q && ((ridx_q == '0) || (rd_pri > best_pri_q));
	assign best_idx_nx = take ? ridx_q : best_idx_q;

	assign scan_last  = (state_q == S_SCAN) && rvalid_q && (ridx_q == last_idx);
	assign shift_done = (state_q == S_SHIFT) && !rd_en && !rvalid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_avail) begin
					if (cmd.op == OP_DEQ && count_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store port controls
	always_comb begin
		cmd_pop = 1'b0;
		rd_en   = 1'b0;
		rd_addr = issue_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {cmd.value, cmd.pri[PRI_W-1:0]};
		case (state_q)
			S_IDLE: begin
				cmd_pop = cmd_avail;
				wr_en   = cmd_avail && (cmd.op == OP_ENQ) && !full;
			end
			S_SCAN: begin
				rd_en = (issue_q < count_q);
			end
			S_SHIFT: begin
				rd_en   = (issue_q < count_q);
				wr_en   = rvalid_q;
				wr_addr = ridx_q - AW'(1);
				wr_data = rdata_q;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	// read and write the entry store
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= rd_en;
			if (cmd_pop) begin
				issue_q <= '0;
			end else if (scan_last) begin
				issue_q <= CW'(best_idx_nx) + CW'(1);
			end else if (rd_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if (wr_en && state_q == S_IDLE) begin
				count_q <= count_q + CW'(1);
			end else if (shift_done) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan tracking and result capture
	always_ff @(posedge clk) begin
		ridx_q <= rd_addr;
		if (state_q == S_SCAN && take) begin
			best_idx_q <= ridx_q;
			best_pri_q <= rd_pri;
			best_val_q <= rd_val;
		end
		if (cmd_pop) begin
			res_val_q <= '0;
			res_pri_q <= '0;
			if (cmd.op == OP_ENQ) begin
				res_status_q <= full ? ST_OVERFLOW : ST_OK;
				res_fill_q   <= full ? FILL_W'(count_q) : FILL_W'(count_q + CW'(1));
			end else if (count_q == '0) begin
				res_status_q <= ST_UNDERFLOW;
				res_fill_q   <= '0;
			end
		end else if (shift_done) begin
			res_val_q    <= best_val_q;
			res_pri_q    <= PRI_IN_W'(best_pri_q);
			res_status_q <= ST_OK;
			res_fill_q   <= FILL_W'(count_q - CW'(1));
		end
		if (state_q == S_DONE && out_free) begin
			out_val_q    <= res_val_q;
			out_pri_q    <= res_pri_q;
			out_status_q <= res_status_q;
			out_fill_q   <= res_fill_q;
		end
	end

	assign res_valid    = out_valid_q;
	assign out_value    = out_val_q;
	assign out_priority = out_pri_q;
	assign status       = out_status_q;
	assign fill_level   = out_fill_q;

endmodule

`default_nettype wire

/* rtl/array_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// Unsorted array priority queue with one result per request.
// ----------------------------------------------------------------------------
// Every request (enqueue or dequeue) returns exactly one result, in request
// order. An enqueue passes through the request stage and the command queue,
// is appended at the tail of the entry store and then loads the result
// register. A dequeue reads every entry of the entry store to find the
// highest priority, then moves each later entry up one place, reading it
// through the read port and writing it back through the write port. The
// engine works on one command at a time; the two-entry command queue keeps
// taking requests, until it is full, while the engine works or a result
// waits on res_stall. The entry store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_unit #(
	parameter int DEPTH         = apq_pkg::DEPTH_DEF,
	parameter int PRIORITY_BITS = apq_pkg::PRI_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                operation,
	input  logic signed [apq_pkg::VALUE_W-1:0]  item_value,
	input  logic        [apq_pkg::PRI_IN_W-1:0] item_priority,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic signed [apq_pkg::VALUE_W-1:0]  out_value,
	output logic        [apq_pkg::PRI_IN_W-1:0] out_priority,
	output logic        [apq_pkg::STATUS_W-1:0] status,
	output logic        [apq_pkg::FILL_W-1:0]   fill_level
);
	import apq_pkg::*;

	cmd_t      front_cmd;
	logic      front_valid;
	cmd_t      head_cmd;
	q_status_t q_status;
	logic      cmd_pop;

	// accept and classify requests
	apq_front #(
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.operation    (operation),
		.item_value   (item_value),
		.item_priority(item_priority),
		.cmd          (front_cmd),
		.cmd_valid    (front_valid),
		.q_status     (q_status)
	);

	// decouple front and back
	apq_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_cmd  (front_cmd),
		.pop       (cmd_pop),
		.head_cmd  (head_cmd),
		.q_status  (q_status)
	);

	// execute commands against the entry store
	apq_back #(
		.DEPTH        (DEPTH),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_avail   (!q_status.empty),
		.cmd_pop     (cmd_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_value   (out_value),
		.out_priority(out_priority),
		.status      (status),
		.fill_level  (fill_level)
	);

endmodule

`default_nettype wire

/* rtl/apq_checker.sv */
// ----------------------------------------------------------------------------
// apq_checker
// Port-level assertions for the array priority queue unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_priority_queue_unit_assert.svh"

module apq_checker #(
	parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_stall,
	input logic signed [apq_pkg::VALUE_W-1:0]  out_value,
	input logic        [apq_pkg::PRI_IN_W-1:0] out_priority,
	input logic        [apq_pkg::STATUS_W-1:0] status,
	input logic        [apq_pkg::FILL_W-1:0]   fill_level
);
	import apq_pkg::*;

	// hold a stalled result
	`APQ_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_value) && $stable(out_priority) && $stable(status) && $stable(fill_level), "stalled result changed")

	// report only defined status codes
	`APQ_ASSERT_IMPLY(a_status_code, res_valid, status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW, "undefined status code")

	// overflow leaves a full store and no data
	`APQ_ASSERT_IMPLY(a_overflow, res_valid && status == ST_OVERFLOW, out_value == '0 && out_priority == '0 && fill_level == FILL_W'(DEPTH), "bad overflow result")

	// underflow reports an empty store and no data
	`APQ_ASSERT_IMPLY(a_underflow, res_valid && status == ST_UNDERFLOW, out_value == '0 && out_priority == '0 && fill_level == '0, "bad underflow result")

endmodule

bind array_priority_queue_unit apq_checker #(
	.DEPTH(DEPTH)
) u_apq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.out_value   (out_value),
	.out_priority(out_priority),
	.status      (status),
	.fill_level  (fill_level)
);

`default_nettype wire
